/* src/z_order_layer_list_top_defines.svh */
// Assertion shorthands for the checker file.
`ifndef Z_ORDER_LAYER_LIST_TOP_DEFINES_SVH
`define Z_ORDER_LAYER_LIST_TOP_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define ZOL_ASSERT_IMP(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |-> (b)) \
    else $error("z order list check failed");

// Next-cycle implication, quiet while reset is high.
`define ZOL_ASSERT_NXT(lbl, ck, rs, a, b) \
  lbl: assert property (@(posedge ck) disable iff (rs) (a) |=> (b)) \
    else $error("z order list check failed");

`endif

/* src/zol_pkg.sv */
`default_nettype none

package zol_pkg;

  localparam int SLOT_W         = 6;
  localparam int SLOTS          = 1 << SLOT_W;
  localparam int CMD_W          = 3;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 7;
  localparam int ZOUT_W         = 32;
  localparam int MAX_ITEMS      = 64;
  localparam int DEPTH_BITS_DEF = 32;
  localparam int WR_SLOTS       = 4;
  localparam int WR_IDX_W       = $clog2(WR_SLOTS);

  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FORWARD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BACKWARD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TO_BACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TO_FRONT = 3'd5;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd6;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOCHG    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] item;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [ZOUT_W-1:0] z_value;
    logic                     present;
    logic [COUNT_W-1:0]       item_count;
  } out_t;

  // What the planner sees of the table once the item and its partner are read.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SLOT_W-1:0]  item;
    logic               s_valid;
    logic [COUNT_W-1:0] count;
    logic [SLOT_W-1:0]  first;
    logic [SLOT_W-1:0]  last;
    logic [SLOT_W-1:0]  s_next;
    logic [SLOT_W-1:0]  s_prev;
    logic [SLOT_W-1:0]  o_addr;
    logic [SLOT_W-1:0]  o_next;
    logic [SLOT_W-1:0]  o_prev;
  } plan_in_t;

  // Register updates decided by the planner.
  typedef struct packed {
    logic [SLOT_W-1:0]  first;
    logic [SLOT_W-1:0]  last;
    logic [COUNT_W-1:0] count;
    logic               set_valid;
    logic               clr_valid;
  } plan_t;

  // One table write with per-field enables.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic              we_z;
    logic              we_n;
    logic              we_p;
    logic [SLOT_W-1:0] next;
    logic [SLOT_W-1:0] prev;
  } wr_t;

  function automatic wr_t wr_entry(logic [SLOT_W-1:0] addr, logic we_z, logic we_n,
                                   logic we_p, logic [SLOT_W-1:0] nx,
                                   logic [SLOT_W-1:0] pv);
    wr_t w;
    w.en   = 1'b1;
    w.addr = addr;
    w.we_z = we_z;
    w.we_n = we_n;
    w.we_p = we_p;
    w.next = nx;
    w.prev = pv;
    return w;
  endfunction

endpackage

`default_nettype wire

/* src/zol_plan.sv */
`default_nettype none

module zol_plan import zol_pkg::*; #(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  plan_in_t                                pin,
  input  logic signed [DEPTH_BITS-1:0]            zs,
  input  logic signed [DEPTH_BITS-1:0]            zo,
  output plan_t                                   upd,
  output out_t                                    res,
  output wr_t [WR_SLOTS-1:0]                      wr,
  output logic [WR_SLOTS-1:0][DEPTH_BITS-1:0]     wz
);

  localparam logic signed [DEPTH_BITS-1:0] ZMAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] ZMIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

  logic signed [DEPTH_BITS-1:0] z_up;
  logic signed [DEPTH_BITS-1:0] z_dn;
  logic signed [DEPTH_BITS-1:0] zres;
  logic signed [ZOUT_W-1:0]     z32;
  logic [STATUS_W-1:0]          status;
  logic                         present;

  // saturate at the signed limits
  assign z_up = (zo == ZMAX) ? zo : zo + DEPTH_BITS'(1);
  assign z_dn = (zo == ZMIN) ? zo : zo - DEPTH_BITS'(1);

  always_comb begin
    wr            = '0;
    wz            = '0;
    status        = ST_NOCHG;
    present       = pin.s_valid;
    zres          = pin.s_valid ? zs : '0;
    upd.first     = pin.first;
    upd.last      = pin.last;
    upd.count     = pin.count;
    upd.set_valid = 1'b0;
    upd.clr_valid = 1'b0;

    if ((pin.command inside {[CMD_FORWARD:CMD_QUERY]}) && !pin.s_valid) begin
      status = ST_NOTFOUND;
    end else begin
      case (pin.command)
        CMD_INSERT: begin
          if (!pin.s_valid) begin
            if (32'(pin.count) >= 32'(MAX_ITEMS)) begin
              status = ST_FULL;
            end else begin
              status        = ST_DONE;
              present       = 1'b1;
              upd.set_valid = 1'b1;
              upd.last      = pin.item;
              upd.count     = pin.count + COUNT_W'(1);
              if (pin.count == '0) begin
                upd.first = pin.item;
                zres      = '0;
                wr[0]     = wr_entry(pin.item, 1'b1, 1'b1, 1'b1, pin.item, pin.item);
                wz[0]     = '0;
              end else begin
                zres  = z_up;
                wr[0] = wr_entry(pin.item, 1'b1, 1'b1, 1'b1, pin.o_next, pin.o_addr);
                wz[0] = z_up;
                wr[1] = wr_entry(pin.o_addr, 1'b0, 1'b1, 1'b0, pin.item, '0);
              end
            end
          end
        end
        CMD_REMOVE: begin
          if (pin.s_valid) begin
            status        = ST_DONE;
            present       = 1'b0;
            zres          = '0;
            upd.clr_valid = 1'b1;
            upd.count     = (pin.count == '0) ? '0 : pin.count - COUNT_W'(1);
            if (pin.item == pin.first) begin
              upd.first = pin.s_next;
            end else begin
              wr[0] = wr_entry(pin.s_prev, 1'b0, 1'b1, 1'b0, pin.s_next, '0);
            end
            if (pin.item == pin.last) begin
              upd.last = pin.s_prev;
            end else begin
              wr[1] = wr_entry(pin.s_next, 1'b0, 1'b0, 1'b1, '0, pin.s_prev);
            end
          end
        end
        CMD_FORWARD: begin
          if (pin.item != pin.last) begin
            status = ST_DONE;
            zres   = zo;
            if (pin.item == pin.first) begin
              upd.first = pin.o_addr;
            end else begin
              wr[0] = wr_entry(pin.s_prev, 1'b0, 1'b1, 1'b0, pin.o_addr, '0);
            end
            wr[1] = wr_entry(pin.o_addr, 1'b1, 1'b1, 1'b1, pin.item, pin.s_prev);
            wz[1] = zs;
            wr[2] = wr_entry(pin.item, 1'b1, 1'b1, 1'b1, pin.o_next, pin.o_addr);
            wz[2] = zo;
            if (pin.o_addr == pin.last) begin
              upd.last = pin.item;
            end else begin
              wr[3] = wr_entry(pin.o_next, 1'b0, 1'b0, 1'b1, '0, pin.item);
            end
          end
        end
        CMD_BACKWARD: begin
          if (pin.item != pin.first) begin
            status = ST_DONE;
            zres   = zo;
            wr[0]  = wr_entry(pin.o_addr, 1'b1, 1'b1, 1'b1, pin.s_next, pin.item);
            wz[0]  = zs;
            wr[1]  = wr_entry(pin.item, 1'b1, 1'b1, 1'b1, pin.o_addr, pin.o_prev);
            wz[1]  = zo;
            if (pin.item == pin.last) begin
              upd.last = pin.o_addr;
            end else begin
              wr[2] = wr_entry(pin.s_next, 1'b0, 1'b0, 1'b1, '0, pin.o_addr);
            end
            if (pin.o_addr == pin.first) begin
              upd.first = pin.item;
            end else begin
              wr[3] = wr_entry(pin.o_prev, 1'b0, 1'b1, 1'b0, pin.item, '0);
            end
          end
        end
        CMD_TO_BACK: begin
          if (pin.item != pin.first) begin
            status = ST_DONE;
            zres   = z_dn;
            wr[0]  = wr_entry(pin.s_prev, 1'b0, 1'b1, 1'b0, pin.s_next, '0);
            if (pin.item == pin.last) begin
              upd.last = pin.s_prev;
            end else begin
              wr[1] = wr_entry(pin.s_next, 1'b0, 1'b0, 1'b1, '0, pin.s_prev);
            end
            wr[2]     = wr_entry(pin.item, 1'b1, 1'b1, 1'b1, pin.o_addr, pin.o_prev);
            wz[2]     = z_dn;
            wr[3]     = wr_entry(pin.o_addr, 1'b0, 1'b0, 1'b1, '0, pin.item);
            upd.first = pin.item;
          end
        end
        CMD_TO_FRONT: begin
          if (pin.item != pin.last) begin
            status = ST_DONE;
            zres   = z_up;
            if (pin.item == pin.first) begin
              upd.first = pin.s_next;
            end else begin
              wr[0] = wr_entry(pin.s_prev, 1'b0, 1'b1, 1'b0, pin.s_next, '0);
            end
            wr[1]    = wr_entry(pin.s_next, 1'b0, 1'b0, 1'b1, '0, pin.s_prev);
            wr[2]    = wr_entry(pin.item, 1'b1, 1'b1, 1'b1, pin.o_next, pin.o_addr);
            wz[2]    = z_up;
            wr[3]    = wr_entry(pin.o_addr, 1'b0, 1'b1, 1'b0, pin.item, '0);
            upd.last = pin.item;
          end
        end
        CMD_QUERY: begin
          status = ST_DONE;
        end
        default: begin
          status = ST_NOCHG;
        end
      endcase
    end
  end

  generate
    if (DEPTH_BITS >= ZOUT_W) begin : g_trunc
      assign z32 = zres[ZOUT_W-1:0];
    end else begin : g_sext
      assign z32 = {{(ZOUT_W-DEPTH_BITS){zres[DEPTH_BITS-1]}}, zres};
    end
  endgenerate

  assign res.status     = status;
  assign res.z_value    = z32;
  assign res.present    = present;
  assign res.item_count = upd.count;

endmodule

`default_nettype wire

/* src/z_order_layer_list_top.sv */
`default_nettype none

// Depth-ordered list of up to 64 drawing items, one command per start pulse.
// A command is taken when start is high and busy is low; its result appears
// on result with done high for exactly one cycle, and the receiver cannot
// stall it. All links and z values live in one table with one read and one
// write per cycle: the item's entry is read, then its partner's (neighbor or
// list end), then the four write slots are played out, each rewriting at most
// one entry. A command that rewrites table entries runs through all four
// slots, even empty ones, before done; a command that rewrites none (query,
// not found, no change, full, removal of the only item) skips them and raises
// done after the partner read. Busy drops as done rises. The table needs no
// clearing after reset, so the block is ready as soon as reset drops.
module z_order_layer_list_top import zol_pkg::*; #(
  parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  request,
  output logic done,
  output out_t result
);

  localparam int ENT_W = DEPTH_BITS + 2 * SLOT_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RDS  = 2'd1;
  localparam logic [1:0] S_RDO  = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  localparam logic [WR_IDX_W-1:0] WR_LAST = WR_IDX_W'(WR_SLOTS - 1);

  logic [1:0]                             state;
  logic [WR_IDX_W-1:0]                    wr_idx;
  logic [SLOTS-1:0]                       slot_valid;
  logic [SLOT_W-1:0]                      first;
  logic [SLOT_W-1:0]                      last;
  logic [COUNT_W-1:0]                     count;

  logic [CMD_W-1:0]                       cmd_q;
  logic [SLOT_W-1:0]                      item_q;
  logic [DEPTH_BITS-1:0]                  s_z;
  logic [SLOT_W-1:0]                      s_next;
  logic [SLOT_W-1:0]                      s_prev;
  logic [SLOT_W-1:0]                      o_addr;
  wr_t [WR_SLOTS-1:0]                     wr_q;
  logic [WR_SLOTS-1:0][DEPTH_BITS-1:0]    wz_q;
  out_t                                   res_q;

  logic [ENT_W-1:0]                       mem [SLOTS];
  logic [ENT_W-1:0]                       rd_q;
  logic                                   rd_en;
  logic [SLOT_W-1:0]                      rd_addr;
  logic [SLOT_W-1:0]                      o_addr_c;
  wr_t                                    wr_cur;
  logic                                   wr_en;

  logic                                   accept;
  plan_in_t                               pin;
  plan_t                                  upd;
  out_t                                   res_c;
  wr_t [WR_SLOTS-1:0]                     wr_c;
  logic [WR_SLOTS-1:0][DEPTH_BITS-1:0]    wz_c;
  logic                                   wr_any;
  logic signed [DEPTH_BITS-1:0]           zs;
  logic signed [DEPTH_BITS-1:0]           zo;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign result = res_q;

  // partner entry: neighbor for swaps, list end for the rest
  always_comb begin
    case (cmd_q)
      CMD_FORWARD:  o_addr_c = rd_q[2*SLOT_W-1:SLOT_W];
      CMD_BACKWARD: o_addr_c = rd_q[SLOT_W-1:0];
      CMD_TO_BACK:  o_addr_c = first;
      default:      o_addr_c = last;
    endcase
  end

  assign rd_en   = accept || (state == S_RDS);
  assign rd_addr = (state == S_IDLE) ? request.item : o_addr_c;
  assign wr_cur  = wr_q[wr_idx];
  assign wr_en   = (state == S_WR) && wr_cur.en;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (wr_en) begin
      if (wr_cur.we_z) begin
        mem[wr_cur.addr][ENT_W-1:2*SLOT_W] <= wz_q[wr_idx];
      end
      if (wr_cur.we_n) begin
        mem[wr_cur.addr][2*SLOT_W-1:SLOT_W] <= wr_cur.next;
      end
      if (wr_cur.we_p) begin
        mem[wr_cur.addr][SLOT_W-1:0] <= wr_cur.prev;
      end
    end
  end

  assign zs = s_z;
  assign zo = rd_q[ENT_W-1:2*SLOT_W];

  always_comb begin
    pin.command = cmd_q;
    pin.item    = item_q;
    pin.s_valid = slot_valid[item_q];
    pin.count   = count;
    pin.first   = first;
    pin.last    = last;
    pin.s_next  = s_next;
    pin.s_prev  = s_prev;
    pin.o_addr  = o_addr;
    pin.o_next  = rd_q[2*SLOT_W-1:SLOT_W];
    pin.o_prev  = rd_q[SLOT_W-1:0];
  end

  zol_plan #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_plan (
    .pin (pin),
    .zs  (zs),
    .zo  (zo),
    .upd (upd),
    .res (res_c),
    .wr  (wr_c),
    .wz  (wz_c)
  );

  always_comb begin
    wr_any = 1'b0;
    for (int i = 0; i < WR_SLOTS; i++) begin
      wr_any = wr_any | wr_c[i].en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wr_idx     <= '0;
      done       <= 1'b0;
      slot_valid <= '0;
      first      <= '0;
      last       <= '0;
      count      <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RDS;
          end
        end
        S_RDS: begin
          state <= S_RDO;
        end
        S_RDO: begin
          first <= upd.first;
          last  <= upd.last;
          count <= upd.count;
          if (upd.set_valid) begin
            slot_valid[item_q] <= 1'b1;
          end
          if (upd.clr_valid) begin
            slot_valid[item_q] <= 1'b0;
          end
          wr_idx <= '0;
          if (wr_any) begin
            state <= S_WR;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_WR: begin
          wr_idx <= wr_idx + WR_IDX_W'(1);
          if (wr_idx == WR_LAST) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= request.command;
      item_q <= request.item;
    end
    if (state == S_RDS) begin
      s_z    <= rd_q[ENT_W-1:2*SLOT_W];
      s_next <= rd_q[2*SLOT_W-1:SLOT_W];
      s_prev <= rd_q[SLOT_W-1:0];
      o_addr <= o_addr_c;
    end
    if (state == S_RDO) begin
      wr_q  <= wr_c;
      wz_q  <= wz_c;
      res_q <= res_c;
    end
  end

endmodule

`default_nettype wire

/* src/zol_chk.sv */
`default_nettype none

`include "z_order_layer_list_top_defines.svh"

module zol_chk import zol_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire out_t result
);

  `ZOL_ASSERT_NXT(a_take_busy, clk, rst, start && !busy, busy)
  `ZOL_ASSERT_IMP(a_done_free, clk, rst, done, !busy && $past(busy))
  `ZOL_ASSERT_IMP(a_absent_zero, clk, rst, done && !result.present, result.z_value == '0)
  `ZOL_ASSERT_IMP(a_miss_absent, clk, rst, done && (result.status == ST_NOTFOUND || result.status == ST_FULL), !result.present)
  `ZOL_ASSERT_IMP(a_present_count, clk, rst, done && result.present, result.item_count != '0)

endmodule

bind z_order_layer_list_top zol_chk u_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
